### sv/isqrt_pkg.sv
// Package for the integer square root pipeline.
// Holds widths, stage counts and the per-stage work record. No dependencies.
`timescale 1ns / 1ps

package isqrt_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int ROOT_WIDTH    = OPERAND_WIDTH / 2;

  // Each stage resolves this many root bits.
  localparam int ITERS_PER_STAGE = 4;
  localparam int STAGE_COUNT =
      (OPERAND_WIDTH + 2 * ITERS_PER_STAGE - 1) / (2 * ITERS_PER_STAGE);

  // The operand is zero-extended to a whole number of stages. Leading zero
  // digits only add leading zero root bits, which are dropped at the output.
  localparam int PAD_ROOT  = ITERS_PER_STAGE * STAGE_COUNT;
  localparam int PAD_WIDTH = 2 * PAD_ROOT;
  localparam int REM_WIDTH = PAD_ROOT + 2;

  typedef struct packed {
    logic [PAD_WIDTH-1:0] op;    // operand digits not yet consumed, MSB first
    logic [REM_WIDTH-1:0] rem;   // partial remainder
    logic [PAD_ROOT-1:0]  root;  // root bits found so far
  } isqrt_work_t;

endpackage

### sv/isqrt_if.sv
// Handshake channels for the integer square root block.
// Depends on isqrt_pkg for the operand and root widths.
`timescale 1ns / 1ps

interface isqrt_in_if import isqrt_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic signed [OPERAND_WIDTH-1:0] operand;

  modport source (output valid, output operand, input ready);
  modport sink   (input valid, input operand, output ready);
endinterface

interface isqrt_out_if import isqrt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ROOT_WIDTH-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

### sv/isqrt_stage.sv
// One pipeline stage of the digit-by-digit square root.
// Resolves ITERS_PER_STAGE root bits and registers the result; uses isqrt_pkg.
`timescale 1ns / 1ps

module isqrt_stage import isqrt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  isqrt_work_t work_i,
  output logic        valid_o,
  input  logic        ready_i,
  output isqrt_work_t work_o
);

  logic        valid_q;
  isqrt_work_t work_q;
  isqrt_work_t work_d;

  always_comb begin
    logic [REM_WIDTH-1:0] shifted;
    logic [REM_WIDTH-1:0] trial;
    work_d = work_i;
    for (int i = 0; i < ITERS_PER_STAGE; i++) begin
      // Bring down the next two operand bits and try the digit one.
      shifted = {work_d.rem[REM_WIDTH-3:0], work_d.op[PAD_WIDTH-1 -: 2]};
      trial   = {work_d.root, 2'b01};
      work_d.op = {work_d.op[PAD_WIDTH-3:0], 2'b00};
      if (shifted >= trial) begin
        work_d.rem  = shifted - trial;
        work_d.root = {work_d.root[PAD_ROOT-2:0], 1'b1};
      end else begin
        work_d.rem  = shifted;
        work_d.root = {work_d.root[PAD_ROOT-2:0], 1'b0};
      end
    end
  end

  // The stage takes a new item when empty or when its item leaves this cycle.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

### sv/integer_square_root_top.sv
// Integer square root: STAGE_COUNT pipeline stages (4 at 32 bits), one item per cycle unless the output stalls.
// Each of the four stages resolves four root bits.
// A stalled output holds its item and back-pressure reaches the input in the same cycle.
// Reset (rst_ni, asynchronous, active low) clears only the stage valid bits.
// Depends on isqrt_pkg, isqrt_if and isqrt_stage.
`timescale 1ns / 1ps

module integer_square_root_top import isqrt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  isqrt_in_if.sink     operand_i,
  isqrt_out_if.source  root_o
);

  logic        valid [STAGE_COUNT+1];
  logic        ready [STAGE_COUNT+1];
  isqrt_work_t work  [STAGE_COUNT+1];

  // A negative operand enters as zero, which yields a zero root.
  always_comb begin
    work[0].rem  = '0;
    work[0].root = '0;
    if (operand_i.operand[OPERAND_WIDTH-1]) begin
      work[0].op = '0;
    end else begin
      work[0].op = {{(PAD_WIDTH-OPERAND_WIDTH){1'b0}}, operand_i.operand};
    end
  end

  assign valid[0]        = operand_i.valid;
  assign operand_i.ready = ready[0];

  for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_stage
    isqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[s]),
      .ready_o (ready[s]),
      .work_i  (work[s]),
      .valid_o (valid[s+1]),
      .ready_i (ready[s+1]),
      .work_o  (work[s+1])
    );
  end

  assign root_o.valid        = valid[STAGE_COUNT];
  assign ready[STAGE_COUNT]  = root_o.ready;
  assign root_o.root         = work[STAGE_COUNT].root[ROOT_WIDTH-1:0];

endmodule

### sim/integer_square_root_top_tb.sv
// Self-checking testbench for integer_square_root_top: floor square roots of signed operands.
// Drives the operand channel in bursts and checks every root against an in-bench model.
// Depends on isqrt_pkg, isqrt_if and the integer_square_root_top RTL.
`timescale 1ns / 1ps

module integer_square_root_top_tb;
  import isqrt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4 * STAGE_COUNT + 8;
  localparam int MAX_REPORTS    = 10;

  logic clk_i;
  logic rst_ni;

  isqrt_in_if  operand_ch ();
  isqrt_out_if root_ch ();

  integer_square_root_top DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .operand_i (operand_ch),
    .root_o    (root_ch)
  );

  logic [ROOT_WIDTH-1:0] pending_roots[$];
  logic [ROOT_WIDTH-1:0] expected_root;
  int                    failures;
  int                    idle_cycles;

  bit                    sender_idles;
  bit                    receiver_stalls;
  int                    burst_left;
  int unsigned           stall_phase;
  logic [31:0]           stall_pattern;

  always #5 clk_i = ~clk_i;

  // Floor square root by the digit-pair method; negative operands give zero.
  function automatic logic [ROOT_WIDTH-1:0] floor_sqrt(input logic [OPERAND_WIDTH-1:0] value);
    logic [63:0] rest;
    logic [63:0] acc;
    logic [63:0] digit;
    rest = '0;
    acc  = '0;
    if (value[OPERAND_WIDTH-1]) begin
      return '0;
    end
    rest[OPERAND_WIDTH-1:0] = value;
    digit = 64'd1 << 62;
    while (digit > rest) begin
      digit = digit >> 2;
    end
    while (digit != 0) begin
      if (rest >= acc + digit) begin
        rest = rest - (acc + digit);
        acc  = (acc >> 1) + digit;
      end else begin
        acc = acc >> 1;
      end
      digit = digit >> 2;
    end
    return acc[ROOT_WIDTH-1:0];
  endfunction

  function automatic logic [OPERAND_WIDTH-1:0] random_operand();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[OPERAND_WIDTH-1:0];
  endfunction

  // Receiver: while stalling, ready follows a 32-bit pattern redrawn whenever stall_phase[5:0] is zero.
  always @(negedge clk_i) begin
    if (stall_phase[5:0] == 6'd0) begin
      stall_pattern = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h1);
    end
    root_ch.ready <= receiver_stalls ? stall_pattern[stall_phase[4:0]] : 1'b1;
    stall_phase = stall_phase + 1;
  end

  // Predicts on every accepted operand and checks every accepted root.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (operand_ch.valid && operand_ch.ready) begin
        pending_roots.push_back(floor_sqrt(operand_ch.operand));
      end
      if (root_ch.valid && root_ch.ready) begin
        if (pending_roots.size() == 0) begin
          if (failures < MAX_REPORTS) begin
            $display("%0t: unexpected root %0d with no item outstanding", $realtime,
                     root_ch.root);
          end
          failures++;
        end else begin
          expected_root = pending_roots.pop_front();
          if (root_ch.root !== expected_root) begin
            if (failures < MAX_REPORTS) begin
              $display("%0t: root mismatch, expected %0d, got %0d", $realtime,
                       expected_root, root_ch.root);
            end
            failures++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((operand_ch.valid && operand_ch.ready) || (root_ch.valid && root_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Sends one item; between bursts the channel goes idle with junk on the operand.
  task automatic send_operand(input logic [OPERAND_WIDTH-1:0] value);
    int gap;
    if (sender_idles && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        operand_ch.valid   <= 1'b0;
        operand_ch.operand <= random_operand();
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk_i);
    operand_ch.valid   <= 1'b1;
    operand_ch.operand <= value;
    do begin
      @(posedge clk_i);
    end while (!operand_ch.ready);
  endtask

  task automatic test_directed_corners();
    int corners[] = '{0, 1, 2, 3, 4, 15, 16, 17, 99, 100, 92681, 92682,
                      2147395599, 2147395600, 2147395601, 2147483646, 2147483647,
                      32'h4000_0000, 32'h3FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                      -1, -2, 32'h8000_0000};
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    foreach (corners[i]) begin
      send_operand(OPERAND_WIDTH'(corners[i]));
    end
  endtask

  task automatic test_random_operands(input int count);
    repeat (count) begin
      send_operand(random_operand());
    end
  endtask

  // Operands at and next to perfect squares, where the last root bit flips.
  task automatic test_near_squares(input int count);
    longint max_pos;
    longint max_root;
    longint root;
    longint value;
    max_pos  = (longint'(1) << (OPERAND_WIDTH - 1)) - 1;
    max_root = floor_sqrt(OPERAND_WIDTH'(max_pos));
    repeat (count) begin
      root  = $urandom_range(0, int'(max_root));
      value = root * root + $urandom_range(0, 2) - 1;
      if (value > max_pos) begin
        value = max_pos;
      end
      send_operand(OPERAND_WIDTH'(value));
    end
  endtask

  // Operands with a random leading-one position, so every root length occurs.
  task automatic test_narrow_magnitudes(input int count);
    int          width;
    logic [63:0] value;
    repeat (count) begin
      width = $urandom_range(1, OPERAND_WIDTH - 1);
      value = {$urandom, $urandom} & ((64'd1 << width) - 1);
      value[width-1] = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        value = -value;
      end
      send_operand(value[OPERAND_WIDTH-1:0]);
    end
  endtask

  task automatic test_back_to_back(input int count);
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    test_random_operands(count);
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task automatic finish_run();
    @(negedge clk_i);
    operand_ch.valid <= 1'b0;
    while (pending_roots.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  endtask

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    operand_ch.valid   = 1'b0;
    operand_ch.operand = '0;
    root_ch.ready      = 1'b0;
    failures           = 0;
    idle_cycles        = 0;
    burst_left         = 0;
    stall_phase        = 0;
    stall_pattern      = 32'hFFFF_FFFF;
    sender_idles       = 1'b1;
    receiver_stalls    = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_corners();
    test_random_operands(500);
    test_near_squares(450);
    test_narrow_magnitudes(450);
    test_back_to_back(300);
    finish_run();
  end

endmodule
